[rtl/core/fuel_pulse_width_calc_macros.svh]
`ifndef FUEL_PULSE_WIDTH_CALC_MACROS_SVH
`define FUEL_PULSE_WIDTH_CALC_MACROS_SVH

// same-cycle implication on clk, off during reset
`define FPW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define FPW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/fpw_pkg.sv]
package fpw_pkg;

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_REQ_FUEL,
		REG_PULSE_MIN,
		REG_PULSE_MAX,
		REG_TEMP_LOW,
		REG_TEMP_HIGH,
		REG_ENRICH_MAX
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        req_fuel;
		logic [15:0]        pulse_min;
		logic [15:0]        pulse_max;
		logic signed [8:0]  temp_low;
		logic signed [8:0]  temp_high;
		logic [8:0]         enrich_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		req_fuel:   16'd8000,
		pulse_min:  16'd500,
		pulse_max:  16'd20000,
		temp_low:   9'sd0,
		temp_high:  9'sd70,
		enrich_max: 9'd150
	};

	// enrichment and lambda constants
	localparam logic [8:0]         ENRICH_NEUTRAL = 9'd100;
	localparam logic signed [11:0] LAM_ONE = 12'sd1000;
	localparam logic signed [11:0] LAM_MIN = 12'sd750;
	localparam logic signed [11:0] LAM_MAX = 12'sd1250;

	// 10^11 = 2^11 * 5^11: shift out 11 bits, then divide by 5^11 with a
	// reciprocal multiply and a small correction
	localparam logic [25:0] PDIV_C  = 26'd48828125;
	localparam logic [26:0] PDIV_C2 = 27'd97656250;
	// floor(2^49 / 5^11), applied to the top 26 of the 49 shifted bits
	localparam logic [23:0] PDIV_M  = 24'd11529215;

	// stage plan
	localparam int EQ_W       = 9;
	localparam int EDIV_BITS  = 3;
	localparam int EDIV_FIRST = 3;
	localparam int EDIV_LAST  = EDIV_FIRST + EQ_W / EDIV_BITS - 1;
	localparam int STG_ENRICH = EDIV_LAST + 1;
	localparam int STG_LAMBDA = STG_ENRICH + 1;
	localparam int STG_PROD   = STG_LAMBDA + 1;
	localparam int STG_RECIP  = STG_PROD + 1;
	localparam int STG_BACK   = STG_RECIP + 1;
	localparam int STG_REM    = STG_BACK + 1;
	localparam int STG_FIX    = STG_REM + 1;
	localparam int NSTG       = STG_FIX + 1;

	typedef struct packed {
		logic        rpm_zero;
		logic [11:0] ve;
		logic [11:0] map;
		logic [10:0] lam;
		logic        cold;
		logic        hot;
		logic [8:0]  dhi;
		logic [8:0]  dlo;
		logic [8:0]  rng;
		logic [19:0] erem;
		logic [9:0]  edsr;
		logic [8:0]  eq;
		logic [27:0] prod_a;
		logic [20:0] prod_b;
		logic [31:0] prod_c;
		logic [48:0] px;
		logic [48:0] pqc;
		logic [27:0] prem;
		logic [23:0] pq;
		logic [10:0] low11;
		logic [15:0] res;
	} pipe_t;

endpackage

[rtl/core/fuel_pulse_width_calc.sv]
// Speed-density injector pulse width: pulse = required_fuel * VE/100% * MAP/100kPa
// * warm-up enrichment % * lambda factor, rounded half up and clamped to
// [pulse_min_us, pulse_max_us]; zero rpm returns pulse_min_us. The datapath is a
// 13-stage pipeline that takes one item per clock while the output is not
// stalled; it passes every item through each stage in order. Its depth is set
// by the enrichment interpolation, a restoring divider by the temperature span
// at three quotient bits per stage (3 stages), and by the final scaling by 10^11,
// which shifts out 2^11 and divides by 5^11 through a reciprocal multiply, a back
// multiply, a remainder subtract and a one-step correction (4 stages); the other
// multiplies take one stage each. Every stage holds only when the stage after it
// is full and held, so bubbles close up and the input stays ready while any stage
// is empty. Registers sit on an APB port at byte address 4*index; write them only
// while no item is in flight.
module fuel_pulse_width_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fpw_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [15:0]                   engine_rpm,
	input  logic [11:0]                   ve_tenths,
	input  logic [11:0]                   map_tenths_kpa,
	input  logic signed [8:0]             coolant_c,
	input  logic signed [10:0]            lambda_corr_milli,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [15:0]                   pulse_width_us
);

	fpw_pkg::cfg_t  cfg_q;
	fpw_pkg::pipe_t pipe_s [1:fpw_pkg::NSTG];
	fpw_pkg::pipe_t nxt    [1:fpw_pkg::NSTG];
	logic           vld_q  [1:fpw_pkg::NSTG];
	logic           stg_en [1:fpw_pkg::NSTG];

	function automatic fpw_pkg::pipe_t stage_entry(
		input logic [15:0]        rpm,
		input logic [11:0]        ve,
		input logic [11:0]        map,
		input logic signed [8:0]  t,
		input logic signed [10:0] lcorr,
		input fpw_pkg::cfg_t      c
	);
		fpw_pkg::pipe_t    r;
		logic signed [11:0] ls;
		logic signed [9:0]  dh;
		logic signed [9:0]  dl;
		logic signed [9:0]  rg;
		r = '0;
		r.rpm_zero = (rpm == 16'd0);
		r.ve = ve;
		r.map = map;
		ls = 12'(lcorr) + fpw_pkg::LAM_ONE;
		if (ls < fpw_pkg::LAM_MIN) begin
			r.lam = 11'(fpw_pkg::LAM_MIN);
		end else if (ls > fpw_pkg::LAM_MAX) begin
			r.lam = 11'(fpw_pkg::LAM_MAX);
		end else begin
			r.lam = ls[10:0];
		end
		r.cold = ($signed(t) <= $signed(c.temp_low));
		r.hot = ($signed(t) >= $signed(c.temp_high));
		dh = 10'(c.temp_high) - 10'(t);
		dl = 10'(t) - 10'(c.temp_low);
		rg = 10'(c.temp_high) - 10'(c.temp_low);
		r.dhi = dh[8:0];
		r.dlo = dl[8:0];
		r.rng = rg[8:0];
		return r;
	endfunction

	function automatic fpw_pkg::pipe_t stage_next(
		input int             stg,
		input fpw_pkg::pipe_t p,
		input fpw_pkg::cfg_t  c
	);
		fpw_pkg::pipe_t r;
		logic [17:0] num;
		logic [19:0] trial;
		logic [8:0]  enr;
		logic [59:0] prod;
		logic [49:0] qmul;
		logic [48:0] pdif;
		logic [26:0] half;
		logic        bitq;
		logic        rem_nz;
		logic        rnd;
		r = p;
		if (stg == fpw_pkg::EDIV_FIRST - 1) begin
			num = 18'(c.enrich_max) * 18'(p.dhi) + 18'(fpw_pkg::ENRICH_NEUTRAL) * 18'(p.dlo);
			r.erem = {1'b0, num, 1'b0} + 20'(p.rng);
			r.edsr = {p.rng, 1'b0};
			r.eq = '0;
			r.prod_a = 28'(c.req_fuel) * 28'(p.ve);
		end else if (stg >= fpw_pkg::EDIV_FIRST && stg <= fpw_pkg::EDIV_LAST) begin
			for (int j = 0; j < fpw_pkg::EDIV_BITS; j++) begin
				trial = 20'(r.edsr) << (fpw_pkg::EQ_W - 1
					- fpw_pkg::EDIV_BITS * (stg - fpw_pkg::EDIV_FIRST) - j);
				bitq = (r.erem >= trial);
				if (bitq) begin
					r.erem = r.erem - trial;
				end
				r.eq = {r.eq[7:0], bitq};
			end
		end else if (stg == fpw_pkg::STG_ENRICH) begin
			enr = p.cold ? c.enrich_max : (p.hot ? fpw_pkg::ENRICH_NEUTRAL : p.eq);
			r.prod_b = 21'(p.map) * 21'(enr);
		end else if (stg == fpw_pkg::STG_LAMBDA) begin
			r.prod_c = 32'(p.prod_b) * 32'(p.lam);
		end else if (stg == fpw_pkg::STG_PROD) begin
			prod = 60'(p.prod_a) * 60'(p.prod_c);
			r.px = prod[59:11];
			r.low11 = prod[10:0];
		end else if (stg == fpw_pkg::STG_RECIP) begin
			// estimate is at most two below the true quotient
			qmul = 50'(p.px[48:23]) * 50'(fpw_pkg::PDIV_M);
			r.pq = qmul[49:26];
		end else if (stg == fpw_pkg::STG_BACK) begin
			qmul = 50'(p.pq) * 50'(fpw_pkg::PDIV_C);
			r.pqc = qmul[48:0];
		end else if (stg == fpw_pkg::STG_REM) begin
			pdif = p.px - p.pqc;
			r.prem = pdif[27:0];
		end else if (stg == fpw_pkg::STG_FIX) begin
			if (p.prem >= 28'(fpw_pkg::PDIV_C2)) begin
				r.prem = p.prem - 28'(fpw_pkg::PDIV_C2);
				r.pq = p.pq + 24'd2;
			end else if (p.prem >= 28'(fpw_pkg::PDIV_C)) begin
				r.prem = p.prem - 28'(fpw_pkg::PDIV_C);
				r.pq = p.pq + 24'd1;
			end
		end else if (stg == fpw_pkg::NSTG) begin
			rem_nz = (p.prem != '0) || (p.low11 != '0);
			half = {p.prem[25:0], p.low11[10]};
			rnd = (half >= 27'(fpw_pkg::PDIV_C));
			if (p.rpm_zero) begin
				r.res = c.pulse_min;
			end else if (p.pq < 24'(c.pulse_min)) begin
				r.res = c.pulse_min;
			end else if (p.pq > 24'(c.pulse_max)
					|| (p.pq == 24'(c.pulse_max) && rem_nz)) begin
				r.res = c.pulse_max;
			end else begin
				r.res = p.pq[15:0] + 16'(rnd);
			end
		end
		return r;
	endfunction

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fpw_pkg::CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (fpw_pkg::reg_idx_t'(paddr[4:2]))
				fpw_pkg::REG_REQ_FUEL: begin
					cfg_q.req_fuel <= pwdata[15:0];
				end
				fpw_pkg::REG_PULSE_MIN: begin
					cfg_q.pulse_min <= pwdata[15:0];
				end
				fpw_pkg::REG_PULSE_MAX: begin
					cfg_q.pulse_max <= pwdata[15:0];
				end
				fpw_pkg::REG_TEMP_LOW: begin
					cfg_q.temp_low <= pwdata[8:0];
				end
				fpw_pkg::REG_TEMP_HIGH: begin
					cfg_q.temp_high <= pwdata[8:0];
				end
				fpw_pkg::REG_ENRICH_MAX: begin
					cfg_q.enrich_max <= pwdata[8:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (fpw_pkg::reg_idx_t'(paddr[4:2]))
			fpw_pkg::REG_REQ_FUEL:   prdata = 32'(cfg_q.req_fuel);
			fpw_pkg::REG_PULSE_MIN:  prdata = 32'(cfg_q.pulse_min);
			fpw_pkg::REG_PULSE_MAX:  prdata = 32'(cfg_q.pulse_max);
			fpw_pkg::REG_TEMP_LOW:   prdata = 32'(cfg_q.temp_low);
			fpw_pkg::REG_TEMP_HIGH:  prdata = 32'(cfg_q.temp_high);
			fpw_pkg::REG_ENRICH_MAX: prdata = 32'(cfg_q.enrich_max);
			default:                 prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

	// pipeline
	assign nxt[1] = stage_entry(engine_rpm, ve_tenths, map_tenths_kpa, coolant_c,
		lambda_corr_milli, cfg_q);

	for (genvar k = 1; k <= fpw_pkg::NSTG; k++) begin : g_stg
		if (k == fpw_pkg::NSTG) begin : g_last
			assign stg_en[k] = !vld_q[k] || result_ready;
		end else begin : g_mid
			assign stg_en[k] = !vld_q[k] || stg_en[k+1];
		end

		if (k == 1) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (stg_en[k]) begin
					vld_q[k] <= item_valid;
				end
			end
		end else begin : g_body
			assign nxt[k] = stage_next(k, pipe_s[k-1], cfg_q);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (stg_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (stg_en[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	assign item_ready = stg_en[1];
	assign result_valid = vld_q[fpw_pkg::NSTG];
	assign pulse_width_us = pipe_s[fpw_pkg::NSTG].res;

endmodule

[rtl/core/fpw_checker.sv]
`include "fuel_pulse_width_calc_macros.svh"

module fpw_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [fpw_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic [15:0]                engine_rpm,
	input logic [11:0]                ve_tenths,
	input logic [11:0]                map_tenths_kpa,
	input logic signed [8:0]          coolant_c,
	input logic signed [10:0]         lambda_corr_milli,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [15:0]                pulse_width_us
);

	// a held result item stays put
	`FPW_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(pulse_width_us), "result item changed or dropped while held")

	// input back-pressure only comes from a full, stalled pipe
	`FPW_ASSERT_IMP(a_ready_only_on_stall, !item_ready, result_valid && !result_ready, "input not ready while output side is free")

	// the written request-fuel register reads back on the next cycle
	`FPW_ASSERT_IMP(a_cfg_readback, (psel && penable && pwrite && pready && paddr[4:2] == fpw_pkg::REG_REQ_FUEL) ##1 (!pwrite && paddr[4:2] == fpw_pkg::REG_REQ_FUEL), prdata[15:0] == $past(pwdata[15:0]), "register readback mismatch")

endmodule

bind fuel_pulse_width_calc fpw_checker u_fpw_checker (.*);
